/* design/slot_table_with_sorted_list_macros.svh */
// Assertion macros shared by the slot table modules.
`ifndef SLOT_TABLE_WITH_SORTED_LIST_MACROS_SVH
`define SLOT_TABLE_WITH_SORTED_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define STL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define STL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/stl_pkg.sv */
// Types, codes and constants of the slot table with sorted list.
package stl_pkg;

    localparam int          SLOT_COUNT_DEF = 32;
    localparam int          LINK_W         = 6;
    localparam logic [7:0]  EMPTY_MARK     = 8'hFF;
    localparam logic [5:0]  NULL_LINK      = 6'h3F;
    localparam logic [7:0]  MAX_VALUE_RST  = 8'd100;
    localparam logic        REG_MAX_VALUE  = 1'b0;

    typedef enum logic [1:0] {
        ACT_INSERT      = 2'd0,
        ACT_DELETE      = 2'd1,
        ACT_LIST_SORTED = 2'd2,
        ACT_LIST_SLOTS  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_BAD_POS   = 3'd1,
        STS_SLOT_FULL = 3'd2,
        STS_TOO_BIG   = 3'd3,
        STS_DUP       = 3'd4,
        STS_NOT_FOUND = 3'd5,
        STS_NO_NODE   = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_I_POS,
        S_I_SCAN,
        S_I_HEAD,
        S_I_HEADRD,
        S_I_WALK,
        S_I_NEWHEAD,
        S_I_LINK,
        S_I_LINK2,
        S_D_SCAN,
        S_D_START,
        S_D_WALK,
        S_D_UNLINK,
        S_D_FREE,
        S_LS_WALK,
        S_LO_CHK,
        S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_INS_CHKPOS,
        OP_SCAN_START,
        OP_SCAN,
        OP_HEAD_RD,
        OP_I_NEWHEAD,
        OP_I_FIRST,
        OP_I_WALK,
        OP_I_LINK,
        OP_I_LINK2,
        OP_D_WALK,
        OP_D_UNLINK,
        OP_D_FREE,
        OP_LS_START,
        OP_LS_EMIT,
        OP_LO_START,
        OP_LO_SKIP,
        OP_LO_EMIT,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    status_we;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_action act;
        logic    pos_bad;
        logic    val_bad;
        logic    head_ok;
        logic    fill_zero;
        logic    s_empty;
        logic    s_match;
        logic    scan_done;
        logic    free_ok;
        logic    pv_lt;
        logic    pv_gt;
        logic    pv_eq;
        logic    pl_ok;
        logic    steps_room;
        logic    steps_lt;
        logic    ls_last;
        logic    lo_last;
        logic    out_free;
    } t_dp_sts;

endpackage

/* design/stl_if.sv */
// Request and result channel interfaces of the slot table.
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] position;
    logic [7:0] value;

    modport source (output valid, action, position, value, input ready);
    modport sink (input valid, action, position, value, output ready);
endinterface

interface stl_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] out_value;
    logic       out_valid;
    logic       last;

    modport source (output valid, status, out_value, out_valid, last, input ready);
    modport sink (input valid, status, out_value, out_valid, last, output ready);
endinterface

/* design/stl_ctrl.sv */
// Sequencing state machine of the slot table.
`include "slot_table_with_sorted_list_macros.svh"

module stl_ctrl
    import stl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Hold state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_sts.act)
                    ACT_INSERT:      n_state = i_sts.pos_bad ? S_EMIT : S_I_POS;
                    ACT_DELETE:      n_state = i_sts.val_bad ? S_EMIT : S_D_SCAN;
                    ACT_LIST_SORTED: n_state = i_sts.head_ok ? S_LS_WALK : S_EMIT;
                    ACT_LIST_SLOTS:  n_state = i_sts.fill_zero ? S_EMIT : S_LO_CHK;
                endcase
            end
            S_I_POS: begin
                if (!i_sts.s_empty || i_sts.val_bad) n_state = S_EMIT;
                else n_state = S_I_SCAN;
            end
            S_I_SCAN: begin
                if (i_sts.s_match) n_state = S_EMIT;
                else if (i_sts.scan_done) n_state = S_I_HEAD;
            end
            S_I_HEAD: begin
                if (!i_sts.free_ok) n_state = S_EMIT;
                else if (!i_sts.head_ok) n_state = S_I_NEWHEAD;
                else n_state = S_I_HEADRD;
            end
            S_I_HEADRD: begin
                if (i_sts.pv_gt) n_state = S_I_NEWHEAD;
                else if (i_sts.pl_ok) n_state = S_I_WALK;
                else n_state = S_I_LINK;
            end
            S_I_WALK: begin
                if (!(i_sts.pv_lt && i_sts.pl_ok && i_sts.steps_room)) n_state = S_I_LINK;
            end
            S_I_NEWHEAD: n_state = S_EMIT;
            S_I_LINK:    n_state = S_I_LINK2;
            S_I_LINK2:   n_state = S_EMIT;
            S_D_SCAN: begin
                if (i_sts.s_match) n_state = S_D_START;
                else if (i_sts.scan_done) n_state = S_EMIT;
            end
            S_D_START: begin
                n_state = i_sts.head_ok ? S_D_WALK : S_EMIT;
            end
            S_D_WALK: begin
                priority if (i_sts.pv_eq) n_state = S_D_UNLINK;
                else if (i_sts.steps_lt && i_sts.pl_ok) n_state = S_D_WALK;
                else n_state = S_EMIT;
            end
            S_D_UNLINK: n_state = S_D_FREE;
            S_D_FREE:   n_state = S_EMIT;
            S_LS_WALK: begin
                if (i_sts.out_free && i_sts.ls_last) n_state = S_IDLE;
            end
            S_LO_CHK: begin
                if (!i_sts.s_empty && i_sts.out_free && i_sts.lo_last) n_state = S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb begin
        o_cmd = '{op: OP_NONE, status_we: 1'b0, status: STS_OK};
        unique case (r_state)
            S_IDLE: begin
                if (accept) o_cmd.op = OP_LATCH;
            end
            S_DISPATCH: begin
                o_cmd.status_we = 1'b1;
                unique case (i_sts.act)
                    ACT_INSERT: begin
                        o_cmd.status = STS_BAD_POS;
                        if (!i_sts.pos_bad) o_cmd.op = OP_INS_CHKPOS;
                    end
                    ACT_DELETE: begin
                        o_cmd.status = STS_TOO_BIG;
                        if (!i_sts.val_bad) o_cmd.op = OP_SCAN_START;
                    end
                    ACT_LIST_SORTED: begin
                        if (i_sts.head_ok) o_cmd.op = OP_LS_START;
                    end
                    ACT_LIST_SLOTS: begin
                        if (!i_sts.fill_zero) o_cmd.op = OP_LO_START;
                    end
                endcase
            end
            S_I_POS: begin
                o_cmd.status_we = 1'b1;
                priority if (!i_sts.s_empty) o_cmd.status = STS_SLOT_FULL;
                else if (i_sts.val_bad) o_cmd.status = STS_TOO_BIG;
                else o_cmd.op = OP_SCAN_START;
            end
            S_I_SCAN: begin
                o_cmd.status_we = i_sts.s_match;
                o_cmd.status    = STS_DUP;
                if (!i_sts.s_match) o_cmd.op = OP_SCAN;
            end
            S_I_HEAD: begin
                o_cmd.status_we = !i_sts.free_ok;
                o_cmd.status    = STS_NO_NODE;
                if (i_sts.free_ok && i_sts.head_ok) o_cmd.op = OP_HEAD_RD;
            end
            S_I_HEADRD: begin
                if (!i_sts.pv_gt) o_cmd.op = OP_I_FIRST;
            end
            S_I_WALK: begin
                if (i_sts.pv_lt) o_cmd.op = OP_I_WALK;
            end
            S_I_NEWHEAD: begin
                o_cmd.op        = OP_I_NEWHEAD;
                o_cmd.status_we = 1'b1;
            end
            S_I_LINK: o_cmd.op = OP_I_LINK;
            S_I_LINK2: begin
                o_cmd.op        = OP_I_LINK2;
                o_cmd.status_we = 1'b1;
            end
            S_D_SCAN: begin
                o_cmd.op        = OP_SCAN;
                o_cmd.status_we = 1'b1;
                o_cmd.status    = STS_NOT_FOUND;
            end
            S_D_START: begin
                if (i_sts.head_ok) o_cmd.op = OP_HEAD_RD;
            end
            S_D_WALK: begin
                o_cmd.op = OP_D_WALK;
            end
            S_D_UNLINK: o_cmd.op = OP_D_UNLINK;
            S_D_FREE: begin
                o_cmd.op        = OP_D_FREE;
                o_cmd.status_we = 1'b1;
            end
            S_LS_WALK: begin
                if (i_sts.out_free) o_cmd.op = OP_LS_EMIT;
            end
            S_LO_CHK: begin
                if (i_sts.s_empty) o_cmd.op = OP_LO_SKIP;
                else if (i_sts.out_free) o_cmd.op = OP_LO_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) o_cmd.op = OP_EMIT;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

    `STL_ASSERT_NXT(a_accept_dispatch, i_clk, i_rst_n, accept, r_state == S_DISPATCH, "accepted transaction did not reach dispatch")
    `STL_ASSERT_NXT(a_emit_holds, i_clk, i_rst_n, (r_state == S_EMIT) && !i_sts.out_free, r_state == S_EMIT, "status result dropped while output busy")
    `STL_ASSERT_NXT(a_link_pair, i_clk, i_rst_n, r_state == S_I_LINK, r_state == S_I_LINK2, "insert link split")

endmodule

/* design/stl_dp.sv */
// Datapath of the slot table: slot and node memories, walk registers, result register.
`include "slot_table_with_sorted_list_macros.svh"

module stl_dp
    import stl_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [1:0] i_action,
    input  logic [7:0] i_position,
    input  logic [7:0] i_value,
    input  logic [7:0] i_max_value,
    input  logic       i_out_ready,
    output t_dp_sts    o_sts,
    output logic       o_out_valid,
    output logic [2:0] o_status,
    output logic [7:0] o_out_value,
    output logic       o_out_vld,
    output logic       o_last
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [LINK_W-1:0] LINK_N = LINK_W'(SLOT_COUNT);
    localparam logic [CW-1:0]     CNT_N  = CW'(SLOT_COUNT);

    // Memories
    logic [7:0]        slot_mem [SLOT_COUNT];
    logic [7:0]        pv_mem   [SLOT_COUNT];
    logic [LINK_W-1:0] pl_mem   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_s_ok, r_pv_ok, r_pl_ok;

    logic [7:0]        r_s_rd, r_pv_rd;
    logic [LINK_W-1:0] r_pl_rd;
    logic              r_s_rd_ok, r_pv_rd_ok, r_pl_rd_ok;

    // Walk and item registers
    t_action           r_act;
    logic [7:0]        r_pos, r_val;
    logic [CW-1:0]     r_cnt, r_steps, r_emit, r_fill;
    logic [AW-1:0]     r_ridx, r_free, r_slot;
    logic              r_free_ok;
    logic [LINK_W-1:0] r_cur, r_prev, r_nxt, r_head;
    t_status           r_status;

    logic              r_out_valid, r_out_vld, r_out_last;
    logic [2:0]        r_out_status;
    logic [7:0]        r_out_value;

    // Memory and result controls
    logic              s_re, s_we, p_re, pv_we, pl_we;
    logic [AW-1:0]     s_raddr, s_waddr, p_raddr, p_waddr;
    logic [7:0]        s_wdata, pv_wdata;
    logic [LINK_W-1:0] pl_wdata;
    logic              out_load, out_vld, out_last, fill_inc, fill_dec;
    logic [2:0]        out_status;
    logic [7:0]        out_value;

    logic [7:0]        s_rdata, pv_rdata;
    logic [LINK_W-1:0] pl_rdata;
    logic              head_ok, pl_ok, prev_ok, nxt_ok, out_free, cnt_room;
    logic              ls_last, lo_last;

    assign s_rdata  = r_s_rd_ok ? r_s_rd : EMPTY_MARK;
    assign pv_rdata = r_pv_rd_ok ? r_pv_rd : EMPTY_MARK;
    assign pl_rdata = r_pl_rd_ok ? r_pl_rd : NULL_LINK;

    assign head_ok  = r_head < LINK_N;
    assign pl_ok    = pl_rdata < LINK_N;
    assign prev_ok  = r_prev < LINK_N;
    assign nxt_ok   = r_nxt < LINK_N;
    assign out_free = !r_out_valid || i_out_ready;
    assign cnt_room = r_cnt < CNT_N;
    assign ls_last  = !pl_ok || (r_steps == CW'(SLOT_COUNT - 1));
    assign lo_last  = (r_emit == (r_fill - CW'(1)));

    // Report status flags
    always_comb begin
        o_sts.act        = r_act;
        o_sts.pos_bad    = r_pos >= 8'(SLOT_COUNT);
        o_sts.val_bad    = (r_val > i_max_value) || (r_val == EMPTY_MARK);
        o_sts.head_ok    = head_ok;
        o_sts.fill_zero  = (r_fill == '0);
        o_sts.s_empty    = (s_rdata == EMPTY_MARK);
        o_sts.s_match    = (s_rdata == r_val);
        o_sts.scan_done  = !cnt_room;
        o_sts.free_ok    = r_free_ok;
        o_sts.pv_lt      = pv_rdata < r_val;
        o_sts.pv_gt      = pv_rdata > r_val;
        o_sts.pv_eq      = pv_rdata == r_val;
        o_sts.pl_ok      = pl_ok;
        o_sts.steps_room = r_steps < CW'(SLOT_COUNT - 1);
        o_sts.steps_lt   = r_steps < CNT_N;
        o_sts.ls_last    = ls_last;
        o_sts.lo_last    = lo_last;
        o_sts.out_free   = out_free;
    end

    // Decode memory and result controls
    always_comb begin
        s_re       = 1'b0;
        s_raddr    = '0;
        s_we       = 1'b0;
        s_waddr    = r_pos[AW-1:0];
        s_wdata    = r_val;
        p_re       = 1'b0;
        p_raddr    = '0;
        pv_we      = 1'b0;
        pl_we      = 1'b0;
        p_waddr    = r_free;
        pv_wdata   = r_val;
        pl_wdata   = NULL_LINK;
        out_load   = 1'b0;
        out_status = STS_OK;
        out_value  = '0;
        out_vld    = 1'b0;
        out_last   = 1'b1;
        fill_inc   = 1'b0;
        fill_dec   = 1'b0;
        unique case (i_cmd.op)
            OP_INS_CHKPOS: begin
                s_re    = 1'b1;
                s_raddr = r_pos[AW-1:0];
            end
            OP_SCAN_START: begin
                s_re = 1'b1;
                p_re = 1'b1;
            end
            OP_SCAN: begin
                s_re    = cnt_room;
                p_re    = cnt_room;
                s_raddr = r_cnt[AW-1:0];
                p_raddr = r_cnt[AW-1:0];
            end
            OP_HEAD_RD, OP_LS_START: begin
                p_re    = 1'b1;
                p_raddr = r_head[AW-1:0];
            end
            OP_I_NEWHEAD: begin
                pv_we    = 1'b1;
                pl_we    = 1'b1;
                pl_wdata = head_ok ? r_head : NULL_LINK;
                s_we     = 1'b1;
                fill_inc = 1'b1;
            end
            OP_I_FIRST: begin
                p_re    = pl_ok;
                p_raddr = pl_rdata[AW-1:0];
            end
            OP_I_WALK: begin
                p_re    = (pv_rdata < r_val) && pl_ok && (r_steps < CW'(SLOT_COUNT - 1));
                p_raddr = pl_rdata[AW-1:0];
            end
            OP_I_LINK: begin
                pv_we    = 1'b1;
                pl_we    = 1'b1;
                pl_wdata = nxt_ok ? r_nxt : NULL_LINK;
                s_we     = 1'b1;
                fill_inc = 1'b1;
            end
            OP_I_LINK2: begin
                pl_we    = 1'b1;
                p_waddr  = r_cur[AW-1:0];
                pl_wdata = LINK_W'(r_free);
            end
            OP_D_WALK: begin
                p_re    = (pv_rdata != r_val) && pl_ok && (r_steps < CNT_N);
                p_raddr = pl_rdata[AW-1:0];
            end
            OP_D_UNLINK: begin
                s_we     = 1'b1;
                s_waddr  = r_slot;
                s_wdata  = EMPTY_MARK;
                pl_we    = prev_ok;
                p_waddr  = r_prev[AW-1:0];
                pl_wdata = r_nxt;
            end
            OP_D_FREE: begin
                pv_we    = 1'b1;
                pl_we    = 1'b1;
                p_waddr  = r_cur[AW-1:0];
                pv_wdata = EMPTY_MARK;
                fill_dec = 1'b1;
            end
            OP_LS_EMIT: begin
                out_load  = 1'b1;
                out_value = pv_rdata;
                out_vld   = 1'b1;
                out_last  = ls_last;
                p_re      = !ls_last;
                p_raddr   = pl_rdata[AW-1:0];
            end
            OP_LO_START: begin
                s_re = 1'b1;
            end
            OP_LO_SKIP: begin
                s_re    = 1'b1;
                s_raddr = r_ridx + AW'(1);
            end
            OP_LO_EMIT: begin
                out_load  = 1'b1;
                out_value = s_rdata;
                out_vld   = 1'b1;
                out_last  = lo_last;
                s_re      = !lo_last;
                s_raddr   = r_ridx + AW'(1);
            end
            OP_EMIT: begin
                out_load   = 1'b1;
                out_status = r_status;
            end
            default: begin
            end
        endcase
    end

    // Write memories and capture registered read data
    always_ff @(posedge i_clk) begin
        if (s_we) slot_mem[s_waddr] <= s_wdata;
        if (pv_we) pv_mem[p_waddr] <= pv_wdata;
        if (pl_we) pl_mem[p_waddr] <= pl_wdata;
        if (s_re) r_s_rd <= slot_mem[s_raddr];
        if (p_re) begin
            r_pv_rd <= pv_mem[p_raddr];
            r_pl_rd <= pl_mem[p_raddr];
        end
    end

    // Track written entries; an unwritten entry reads as the empty mark or null link
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_ok     <= '0;
            r_pv_ok    <= '0;
            r_pl_ok    <= '0;
            r_s_rd_ok  <= 1'b0;
            r_pv_rd_ok <= 1'b0;
            r_pl_rd_ok <= 1'b0;
        end else begin
            if (s_we) r_s_ok[s_waddr] <= 1'b1;
            if (pv_we) r_pv_ok[p_waddr] <= 1'b1;
            if (pl_we) r_pl_ok[p_waddr] <= 1'b1;
            if (s_re) r_s_rd_ok <= r_s_ok[s_raddr];
            if (p_re) begin
                r_pv_rd_ok <= r_pv_ok[p_raddr];
                r_pl_rd_ok <= r_pl_ok[p_raddr];
            end
        end
    end

    // Advance walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.status_we) r_status <= i_cmd.status;
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_act <= t_action'(i_action);
                r_pos <= i_position;
                r_val <= i_value;
            end
            OP_SCAN_START: begin
                r_ridx    <= '0;
                r_cnt     <= CW'(1);
                r_free_ok <= 1'b0;
            end
            OP_SCAN: begin
                if ((pv_rdata == EMPTY_MARK) && !r_free_ok) begin
                    r_free    <= r_ridx;
                    r_free_ok <= 1'b1;
                end
                if (s_rdata == r_val) r_slot <= r_ridx;
                if (cnt_room) begin
                    r_ridx <= r_cnt[AW-1:0];
                    r_cnt  <= r_cnt + CW'(1);
                end
            end
            OP_HEAD_RD: begin
                r_cur   <= r_head;
                r_prev  <= NULL_LINK;
                r_steps <= '0;
            end
            OP_I_FIRST: r_nxt <= pl_rdata;
            OP_I_WALK: begin
                if (pv_rdata < r_val) begin
                    r_cur   <= r_nxt;
                    r_nxt   <= pl_rdata;
                    r_steps <= r_steps + CW'(1);
                end
            end
            OP_D_WALK: begin
                if (pv_rdata == r_val) begin
                    r_nxt <= pl_rdata;
                end else begin
                    r_prev  <= r_cur;
                    r_cur   <= pl_rdata;
                    r_steps <= r_steps + CW'(1);
                end
            end
            OP_LS_START: r_steps <= '0;
            OP_LS_EMIT:  r_steps <= r_steps + CW'(1);
            OP_LO_START: begin
                r_ridx <= '0;
                r_emit <= '0;
            end
            OP_LO_SKIP: r_ridx <= r_ridx + AW'(1);
            OP_LO_EMIT: begin
                r_ridx <= r_ridx + AW'(1);
                r_emit <= r_emit + CW'(1);
            end
            default: begin
            end
        endcase
    end

    // Hold list head and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= NULL_LINK;
            r_fill <= '0;
        end else begin
            if (i_cmd.op == OP_I_NEWHEAD) r_head <= LINK_W'(r_free);
            else if ((i_cmd.op == OP_D_UNLINK) && !prev_ok) r_head <= r_nxt;
            if (fill_inc) r_fill <= r_fill + CW'(1);
            else if (fill_dec) r_fill <= r_fill - CW'(1);
        end
    end

    // Load result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= out_status;
            r_out_value  <= out_value;
            r_out_vld    <= out_vld;
            r_out_last   <= out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_value = r_out_value;
    assign o_out_vld   = r_out_vld;
    assign o_last      = r_out_last;

    `STL_ASSERT_IMP(a_load_free, i_clk, i_rst_n, out_load, !r_out_valid || i_out_ready, "result overwritten before taken")
    `STL_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CNT_N, "fill count beyond slot count")
    `STL_ASSERT_NXT(a_fill_inc, i_clk, i_rst_n, fill_inc, r_fill == CW'($past(r_fill) + 1'b1), "fill count missed insert")

endmodule

/* design/slot_table_with_sorted_list.sv */
// Slot table with sorted list: top level with configuration register.
//
// Slot table of SLOT_COUNT unique byte values with an ascending list linked
// through a node pool of the same depth. One transaction is worked at a time;
// the next request is taken once the last result of the current one is in
// the output register. The slot and node memories are read one entry per
// clock, with listings held while the output register is busy. Insert does a
// full slot sweep for the duplicate and free-node search, then a walk to the
// insertion point; delete does the sweep up to the matching slot, then the
// walk to its node; a sorted listing walks the list value by value, and a
// slot-order listing steps through the slots up to the last filled one.
// Errors found by the early checks skip the sweep and walk. Both stores read
// as empty right after reset, with no clearing pass. max_value sits at byte
// address 0.
module slot_table_with_sorted_list
    import stl_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stl_in_if.sink      i_in,
    stl_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_max_value;
    logic       in_ready;
    t_dp_cmd    cmd;
    t_dp_sts    sts;

    // Configuration register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= MAX_VALUE_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_VALUE)) begin
            r_max_value <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_VALUE) ? {24'd0, r_max_value} : 32'd0;

    assign i_in.ready = in_ready;

    stl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    stl_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_in.action),
        .i_position  (i_in.position),
        .i_value     (i_in.value),
        .i_max_value (r_max_value),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status),
        .o_out_value (o_out.out_value),
        .o_out_vld   (o_out.out_valid),
        .o_last      (o_out.last)
    );

endmodule
